[rtl/cbpe_pkg.sv]
// shared constants for the cubic bezier point evaluator
package cbpe_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int NUM_POINTS = 4;
  localparam int NUM_AXES   = 2;
  localparam int NUM_REGS   = NUM_POINTS * NUM_AXES;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

endpackage

[rtl/cbpe_weight.sv]
// two-stage pipeline that forms the four bernstein weights from t
module cbpe_weight
  import cbpe_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [T_FRAC_BITS:0]   param_t_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [T_FRAC_BITS:0]   weight_o [NUM_POINTS]
);

  localparam int TW  = T_FRAC_BITS + 1;
  localparam int PW  = 2 * TW;
  localparam int PW3 = PW + 2;
  localparam logic [TW-1:0]  ONE   = TW'(1) << T_FRAC_BITS;
  localparam logic [PW-1:0]  HALF  = PW'(1) << (T_FRAC_BITS - 1);
  localparam logic [PW3-1:0] HALF3 = PW3'(1) << (T_FRAC_BITS - 1);

  logic          valid_a_q, valid_b_q;
  logic          ready_a, ready_b;
  logic [TW-1:0] t_clamp, u_val;
  logic [PW-1:0] tt_full, uu_full;
  logic [TW-1:0] t_q, u_q, tt_q, uu_q;
  logic [PW-1:0] p_uuu, p_uut, p_ttu, p_ttt;
  logic [PW-1:0] w0_full, w3_full;
  logic [PW3-1:0] w1_full, w2_full;
  logic [TW-1:0] w_d [NUM_POINTS];
  logic [TW-1:0] w_q [NUM_POINTS];

  assign ready_b    = ~valid_b_q | out_ready_i;
  assign ready_a    = ~valid_a_q | ready_b;
  assign in_ready_o = ready_a;

  // stage a: clamp, complement, squares
  always_comb begin
    t_clamp = (param_t_i > ONE) ? ONE : param_t_i;
    u_val   = ONE - t_clamp;
    tt_full = PW'(t_clamp) * PW'(t_clamp) + HALF;
    uu_full = PW'(u_val) * PW'(u_val) + HALF;
  end

  // stage b: cubic terms
  always_comb begin
    p_uuu   = PW'(uu_q) * PW'(u_q);
    p_uut   = PW'(uu_q) * PW'(t_q);
    p_ttu   = PW'(tt_q) * PW'(u_q);
    p_ttt   = PW'(tt_q) * PW'(t_q);
    w0_full = p_uuu + HALF;
    w3_full = p_ttt + HALF;
    w1_full = (PW3'(p_uut) << 1) + PW3'(p_uut) + HALF3;
    w2_full = (PW3'(p_ttu) << 1) + PW3'(p_ttu) + HALF3;
    w_d[0]  = TW'(w0_full >> T_FRAC_BITS);
    w_d[1]  = TW'(w1_full >> T_FRAC_BITS);
    w_d[2]  = TW'(w2_full >> T_FRAC_BITS);
    w_d[3]  = TW'(w3_full >> T_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      t_q  <= t_clamp;
      u_q  <= u_val;
      tt_q <= TW'(tt_full >> T_FRAC_BITS);
      uu_q <= TW'(uu_full >> T_FRAC_BITS);
    end
    if (ready_b && valid_a_q) begin
      w_q <= w_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign weight_o    = w_q;

endmodule

[rtl/cbpe_blend.sv]
// three-stage pipeline that blends control points by the weights and rounds
module cbpe_blend
  import cbpe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [T_FRAC_BITS:0]          weight_i [NUM_POINTS],
  input  logic signed [COORD_WIDTH-1:0] ctrl_i [NUM_REGS],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o
);

  localparam int TW  = T_FRAC_BITS + 1;
  localparam int PRW = COORD_WIDTH + TW + 1;
  localparam int AW  = PRW + 2;
  localparam logic signed [AW-1:0] HALF   = AW'(1) << (T_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO =
    {{(AW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  logic valid_c_q, valid_d_q, valid_e_q;
  logic ready_c, ready_d, ready_e;

  logic signed [PRW-1:0]         prod_d [NUM_AXES][NUM_POINTS];
  logic signed [PRW-1:0]         prod_q [NUM_AXES][NUM_POINTS];
  logic signed [AW-1:0]          acc_d  [NUM_AXES];
  logic signed [AW-1:0]          acc_q  [NUM_AXES];
  logic signed [AW-1:0]          shifted [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] sat_d  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] sat_q  [NUM_AXES];

  assign ready_e    = ~valid_e_q | out_ready_i;
  assign ready_d    = ~valid_d_q | ready_e;
  assign ready_c    = ~valid_c_q | ready_d;
  assign in_ready_o = ready_c;

  // stage c: weighted coordinates
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        prod_d[ax][i] = PRW'($signed({1'b0, weight_i[i]})) *
                        PRW'(ctrl_i[NUM_AXES * i + ax]);
      end
    end
  end

  // stage d: accumulate with rounding offset
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      acc_d[ax] = AW'(prod_q[ax][0]) + AW'(prod_q[ax][1]) +
                  AW'(prod_q[ax][2]) + AW'(prod_q[ax][3]) + HALF;
    end
  end

  // stage e: floor shift and saturate
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      shifted[ax] = acc_q[ax] >>> T_FRAC_BITS;
      if (shifted[ax] > SAT_HI) begin
        sat_d[ax] = SAT_HI[COORD_WIDTH-1:0];
      end else if (shifted[ax] < SAT_LO) begin
        sat_d[ax] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        sat_d[ax] = shifted[ax][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
    end else begin
      if (ready_c) begin
        valid_c_q <= in_valid_i;
      end
      if (ready_d) begin
        valid_d_q <= valid_c_q;
      end
      if (ready_e) begin
        valid_e_q <= valid_d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (ready_d && valid_c_q) begin
      acc_q <= acc_d;
    end
    if (ready_e && valid_d_q) begin
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = valid_e_q;
  assign point_x_o   = sat_q[AXIS_X];
  assign point_y_o   = sat_q[AXIS_Y];

endmodule

[rtl/cubic_bezier_point_eval.sv]
// cubic bezier point evaluator top level: control point registers and pipeline
// items pass through 5 register stages (weight a, b; blend c, d, e), the first loaded at accept
// throughput: one item per cycle while out_ready_i does not stall the output, each stage a registered arithmetic step
// stalls hold each stage; empty stages still fill while the output waits
// reset clears all stage valid bits and sets every control point to zero
module cubic_bezier_point_eval
  import cbpe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [T_FRAC_BITS:0]          param_t_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o
);

  logic signed [COORD_WIDTH-1:0] ctrl_q [NUM_REGS];
  logic [T_FRAC_BITS:0]          weight [NUM_POINTS];
  logic                          wgt_valid, wgt_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      ctrl_q[cfg_idx_i] <= $signed(cfg_data_i);
    end
  end

  cbpe_weight #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .param_t_i   (param_t_i),
    .out_valid_o (wgt_valid),
    .out_ready_i (wgt_ready),
    .weight_o    (weight)
  );

  cbpe_blend #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wgt_valid),
    .in_ready_o  (wgt_ready),
    .weight_i    (weight),
    .ctrl_i      (ctrl_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o)
  );

endmodule

[tb/tb_cubic_bezier_point_eval.sv]
// self-checking testbench for the cubic bezier point evaluator
module tb_cubic_bezier_point_eval;
  import cbpe_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int TF = T_FRAC_BITS_DEF;
  localparam longint T_ONE = longint'(1) << TF;
  localparam longint T_HALF = longint'(1) << (TF - 1);
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [TF:0] param_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } curve_point_t;

  typedef enum int {
    CURVE_MAX,
    CURVE_MIN,
    CURVE_ZIGZAG,
    CURVE_RANDOM
  } curve_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  param_t param_t_in = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  coord_t point_x_o;
  coord_t point_y_o;

  coord_t ctrl_pts [NUM_POINTS][NUM_AXES];
  param_t t_pending [$];
  curve_point_t point_expected [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_id = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int stall_cnt = 0;

  cubic_bezier_point_eval uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .param_t_i  (param_t_in),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic coord_t blend_axis(input longint w [NUM_POINTS], input int axis);
    longint acc;
    acc = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      acc += w[i] * longint'(ctrl_pts[i][axis]);
    end
    acc = (acc + T_HALF) >>> TF;
    if (acc > COORD_MAX) acc = COORD_MAX;
    if (acc < COORD_MIN) acc = COORD_MIN;
    return coord_t'(acc);
  endfunction

  function automatic curve_point_t eval_curve(input param_t t_raw);
    longint t, u, tt, uu;
    longint w [NUM_POINTS];
    curve_point_t pt;
    t = longint'(t_raw);
    if (t > T_ONE) t = T_ONE;
    u = T_ONE - t;
    tt = (t * t + T_HALF) >> TF;
    uu = (u * u + T_HALF) >> TF;
    w[0] = (uu * u + T_HALF) >> TF;
    w[1] = (3 * uu * t + T_HALF) >> TF;
    w[2] = (3 * tt * u + T_HALF) >> TF;
    w[3] = (tt * t + T_HALF) >> TF;
    pt.x = blend_axis(w, AXIS_X);
    pt.y = blend_axis(w, AXIS_Y);
    return pt;
  endfunction

  function automatic param_t rand_param();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return param_t'($urandom_range(0, int'(T_ONE)));
    if (pick < 90) return param_t'($urandom_range(int'(T_ONE) + 1, int'(2 * T_ONE - 1)));
    case ($urandom_range(0, 3))
      0: return param_t'(0);
      1: return param_t'(1);
      2: return param_t'(T_ONE - 1);
      default: return param_t'(T_ONE);
    endcase
  endfunction

  function automatic coord_t shape_coord(input curve_shape_e shape, input int idx);
    case (shape)
      CURVE_MAX: return coord_t'(COORD_MAX);
      CURVE_MIN: return coord_t'(COORD_MIN);
      CURVE_ZIGZAG: begin
        if (((idx / NUM_AXES) % 2 == 1) ^ (idx % NUM_AXES == AXIS_Y)) return coord_t'(COORD_MAX);
        return coord_t'(COORD_MIN);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return coord_t'(COORD_MAX);
          1: return coord_t'(COORD_MIN);
          default: return coord_t'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic load_curve(input curve_shape_e shape);
    coord_t val;
    for (int i = 0; i < NUM_REGS; i++) begin
      val = shape_coord(shape, i);
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_data <= val;
      ctrl_pts[i / NUM_AXES][i % NUM_AXES] = val;
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (t_pending.size() != 0 || in_valid || point_expected.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        point_expected.push_back(eval_curve(param_t_in));
      end
      if (!in_valid || in_ready_o) begin
        if (t_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          param_t_in <= t_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    curve_point_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (point_expected.size() == 0) begin
          $error("unexpected item: point_x %0d point_y %0d", point_x_o, point_y_o);
          mismatches++;
        end else begin
          want = point_expected.pop_front();
          if (point_x_o !== want.x) begin
            $error("point_x mismatch: expected %0d, actual %0d", want.x, point_x_o);
            mismatches++;
          end
          if (point_y_o !== want.y) begin
            $error("point_y mismatch: expected %0d, actual %0d", want.y, point_y_o);
            mismatches++;
          end
        end
      end
      if (hold_id != hold_seen) begin
        hold_seen <= hold_id;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    param_t directed [$];
    for (int p = 0; p < NUM_POINTS; p++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ctrl_pts[p][a] = '0;
      end
    end
    send_idle_pct = 26;
    recv_idle_pct = 49;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset curve is all zero
    t_pending.push_back(param_t'(0));
    t_pending.push_back(param_t'(T_ONE));
    wait_idle();

    load_curve(CURVE_ZIGZAG);
    directed = '{0, 1, 2, 16384, 21845, 32767, 32768, 32769, 43690, 49152,
                 65535, 65536, 65537, 98304, 131071};
    foreach (directed[i]) t_pending.push_back(directed[i]);
    wait_idle();

    // all corners at the max: weight overshoot saturates
    load_curve(CURVE_MAX);
    directed = '{0, 21845, 32768, 43690, 65536};
    foreach (directed[i]) t_pending.push_back(directed[i]);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 49;
      end else if (ph < 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: load_curve(CURVE_MAX);
        1: load_curve(CURVE_MIN);
        2: load_curve(CURVE_ZIGZAG);
        default: load_curve(CURVE_RANDOM);
      endcase
      if (ph == 4) hold_id++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        t_pending.push_back(rand_param());
      end
      wait_idle();
    end

    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && point_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
